### src/phcs_pkg.sv
// Shared types and constants for the packet header checksum sync gate.
package phcs_pkg;

  localparam int LEN_W = 21;
  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] SYNC_COMMAND = 32'h434e_5953;
  localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [LEN_W-1:0] LEN_LIMIT_RESET = 21'd4096;
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  typedef enum logic {
    CFG_LEN_LIMIT = 1'b0,
    CFG_EXPECTED_TOKEN = 1'b1
  } cfg_index_t;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_BYTE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    V_FORWARD = 3'd0,
    V_BAD_MAGIC = 3'd1,
    V_TOO_LONG = 3'd2,
    V_BAD_SUM = 3'd3,
    V_SYNC_ON = 3'd4,
    V_SYNC_OFF = 3'd5,
    V_SYNC_IGN = 3'd6,
    V_DROPPED = 3'd7
  } verdict_t;

  typedef struct packed {
    logic kind;
    logic [WORD_W-1:0] command;
    logic [WORD_W-1:0] arg_zero;
    logic [WORD_W-1:0] arg_one;
    logic [WORD_W-1:0] payload_length;
    logic [WORD_W-1:0] check_word;
    logic [WORD_W-1:0] magic_word;
    logic [7:0] payload_byte;
  } in_t;

  typedef struct packed {
    verdict_t verdict;
    logic [WORD_W-1:0] out_command;
    logic [WORD_W-1:0] out_arg_zero;
    logic [WORD_W-1:0] out_arg_one;
    logic [LEN_W-1:0] out_length;
  } out_t;

  typedef struct packed {
    verdict_t verdict;
    logic set_online;
    logic clear_online;
  } judge_t;

endpackage

### src/phcs_judge.sv
// End-of-packet judgement: sum check, SYNC handling and online gating.
module phcs_judge (
  input  logic [31:0]     sum,
  input  logic [31:0]     check,
  input  logic [31:0]     command,
  input  logic [31:0]     arg_zero,
  input  logic [31:0]     arg_one,
  input  logic [31:0]     token,
  input  logic            online,
  output phcs_pkg::judge_t judge
);
  import phcs_pkg::*;

  always_comb begin
    judge = '{verdict: V_FORWARD, set_online: 1'b0, clear_online: 1'b0};
    if (sum != check) begin
      judge.verdict = V_BAD_SUM;
    end else if (command == SYNC_COMMAND) begin
      if (arg_zero == '0) begin
        judge.verdict = V_SYNC_OFF;
        judge.clear_online = 1'b1;
      end else if (arg_one == token) begin
        judge.verdict = V_SYNC_ON;
        judge.set_online = 1'b1;
      end else begin
        judge.verdict = V_SYNC_IGN;
      end
    end else begin
      judge.verdict = online ? V_FORWARD : V_DROPPED;
    end
  end

endmodule

### src/packet_header_checksum_sync_gate.sv
// Top level: header check, payload byte sum and SYNC-gated packet verdicts.
//
// Items enter on in_valid/in_ready as in_data: a header (kind 0) opens a
// packet, then one payload byte per transaction (kind 1). Each finished or
// rejected packet gives one verdict transaction on out_valid/out_ready.
// A rejected header, a zero-length header or the last payload byte of an
// open packet produce a result; other items produce none.
// Latency: a result is valid in the cycle after the item that caused it.
// Throughput: one item per cycle while in_ready is high; the sum and byte
// count update in the cycle an item is taken, so the next item may follow at once.
// The output register holds a result until taken; a new item is taken in
// the same cycle that the held result leaves, so a stalled receiver only
// blocks the input while a result is held and out_ready is low.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 max
// payload, 1 expected token) at the clock edge; write only when idle.
// Reset (rst, synchronous): no packet open, offline, no result held,
// max payload 4096, token zero; in_ready is low and writes are ignored
// while rst is high.
module packet_header_checksum_sync_gate (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  phcs_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output phcs_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data
);
  import phcs_pkg::*;

  logic [LEN_W-1:0]  len_limit;
  logic [WORD_W-1:0] expected_token;
  logic [LEN_W-1:0]  bytes_left;
  logic [WORD_W-1:0] running_sum;
  logic [WORD_W-1:0] held_command;
  logic [WORD_W-1:0] held_arg_zero;
  logic [WORD_W-1:0] held_arg_one;
  logic [WORD_W-1:0] held_check;
  logic [LEN_W-1:0]  held_length;
  logic              online;

  logic              fire;
  logic              is_header;
  logic              bad_magic;
  logic              too_long;
  logic [LEN_W-1:0]  len_sat;
  logic [WORD_W-1:0] sum_next;
  logic              last_byte;
  logic              finish;
  logic              result_valid;
  out_t              result;
  logic [WORD_W-1:0] j_sum;
  logic [WORD_W-1:0] j_check;
  logic [WORD_W-1:0] j_command;
  logic [WORD_W-1:0] j_arg_zero;
  logic [WORD_W-1:0] j_arg_one;
  judge_t            judge;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign fire = in_valid && in_ready;
  assign is_header = (in_data.kind == KIND_HEADER);

  always_comb begin
    bad_magic = (in_data.magic_word != (in_data.command ^ ALL_ONES));
    too_long = (in_data.payload_length > {{(WORD_W-LEN_W){1'b0}}, len_limit});
    len_sat = (|in_data.payload_length[WORD_W-1:LEN_W]) ? LEN_SAT
                                                        : in_data.payload_length[LEN_W-1:0];
    sum_next = running_sum + {{(WORD_W-8){1'b0}}, in_data.payload_byte};
    last_byte = (bytes_left == {{(LEN_W-1){1'b0}}, 1'b1});
  end

  // Zero-length header is judged straight from the header words with a zero sum.
  always_comb begin
    if (is_header) begin
      j_sum = '0;
      j_check = in_data.check_word;
      j_command = in_data.command;
      j_arg_zero = in_data.arg_zero;
      j_arg_one = in_data.arg_one;
    end else begin
      j_sum = sum_next;
      j_check = held_check;
      j_command = held_command;
      j_arg_zero = held_arg_zero;
      j_arg_one = held_arg_one;
    end
  end

  phcs_judge u_judge (
    .sum      (j_sum),
    .check    (j_check),
    .command  (j_command),
    .arg_zero (j_arg_zero),
    .arg_one  (j_arg_one),
    .token    (expected_token),
    .online   (online),
    .judge    (judge)
  );

  always_comb begin
    finish = 1'b0;
    result_valid = 1'b0;
    result = '{verdict: judge.verdict, out_command: in_data.command,
               out_arg_zero: in_data.arg_zero, out_arg_one: in_data.arg_one,
               out_length: len_sat};
    if (is_header) begin
      if (bad_magic) begin
        result_valid = 1'b1;
        result.verdict = V_BAD_MAGIC;
      end else if (too_long) begin
        result_valid = 1'b1;
        result.verdict = V_TOO_LONG;
      end else if (in_data.payload_length == '0) begin
        result_valid = 1'b1;
        finish = 1'b1;
      end
    end else if (bytes_left != '0 && last_byte) begin
      result_valid = 1'b1;
      finish = 1'b1;
      result.out_command = held_command;
      result.out_arg_zero = held_arg_zero;
      result.out_arg_one = held_arg_one;
      result.out_length = held_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_limit <= LEN_LIMIT_RESET;
      expected_token <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEN_LIMIT:      len_limit <= cfg_data[LEN_W-1:0];
        CFG_EXPECTED_TOKEN: expected_token <= cfg_data;
        default:            len_limit <= len_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      online <= 1'b0;
    end else if (fire) begin
      if (is_header) begin
        // Abandon any open packet; open a new one only on a good, non-empty header.
        bytes_left <= (bad_magic || too_long) ? '0 : in_data.payload_length[LEN_W-1:0];
      end else if (bytes_left != '0) begin
        bytes_left <= bytes_left - {{(LEN_W-1){1'b0}}, 1'b1};
      end
      if (finish && judge.set_online) begin
        online <= 1'b1;
      end else if (finish && judge.clear_online) begin
        online <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_command <= '0;
      held_arg_zero <= '0;
      held_arg_one <= '0;
      held_check <= '0;
      held_length <= '0;
      running_sum <= '0;
    end else if (fire) begin
      if (is_header) begin
        if (!bad_magic && !too_long) begin
          held_command <= in_data.command;
          held_arg_zero <= in_data.arg_zero;
          held_arg_one <= in_data.arg_one;
          held_check <= in_data.check_word;
          held_length <= in_data.payload_length[LEN_W-1:0];
          running_sum <= '0;
        end
      end else if (bytes_left != '0) begin
        running_sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= result_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result_valid) begin
      out_data <= result;
    end
  end

  a_bad_magic_verdict: assert property (@(posedge clk) disable iff (rst)
    fire && is_header && bad_magic |=> out_valid && out_data.verdict == V_BAD_MAGIC)
    else $error("bad magic header did not give its verdict");

  a_stray_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    fire && !is_header && bytes_left == '0 |=> !out_valid && bytes_left == '0)
    else $error("byte outside a packet changed state or gave a result");

  a_sync_on_sets_online: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict == V_SYNC_ON |-> online)
    else $error("sync online verdict without online flag");

  a_sync_off_clears_online: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict == V_SYNC_OFF |-> !online)
    else $error("sync offline verdict with online flag set");

  a_open_within_length: assert property (@(posedge clk) disable iff (rst)
    bytes_left != '0 |-> bytes_left <= held_length)
    else $error("byte count exceeds packet length");

endmodule

### dv/phcs_gate_checker.sv
// Checker for the packet gate: predicts verdicts from accepted items and compares results.
`timescale 1ns / 100ps

module phcs_gate_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  phcs_pkg::in_t   in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  phcs_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data,
  output int unsigned     fail_count,
  output int unsigned     pending,
  output int unsigned     results_seen,
  output bit [7:0]        verdicts_seen
);
  import phcs_pkg::*;

  // Own copy of the gate state and its registers
  logic [LEN_W-1:0]  pkt_bytes_left;
  logic [WORD_W-1:0] pkt_sum;
  logic [WORD_W-1:0] pkt_cmd;
  logic [WORD_W-1:0] pkt_arg0;
  logic [WORD_W-1:0] pkt_arg1;
  logic [WORD_W-1:0] pkt_check;
  logic [LEN_W-1:0]  pkt_len;
  logic              link_online;
  logic [LEN_W-1:0]  lim_payload;
  logic [WORD_W-1:0] token_want;

  out_t verdicts_due [$];

  // Judge a finished packet (last byte arrived, or zero length) and queue its verdict
  task automatic finish_open_packet();
    out_t res;
    if (pkt_sum != pkt_check) begin
      res.verdict = V_BAD_SUM;
    end else if (pkt_cmd == SYNC_COMMAND) begin
      if (pkt_arg0 == '0) begin
        link_online = 1'b0;
        res.verdict = V_SYNC_OFF;
      end else if (pkt_arg1 == token_want) begin
        link_online = 1'b1;
        res.verdict = V_SYNC_ON;
      end else begin
        res.verdict = V_SYNC_IGN;
      end
    end else begin
      res.verdict = link_online ? V_FORWARD : V_DROPPED;
    end
    res.out_command = pkt_cmd;
    res.out_arg_zero = pkt_arg0;
    res.out_arg_one = pkt_arg1;
    res.out_length = pkt_len;
    verdicts_due.push_back(res);
  endtask

  task automatic predict_verdict(input in_t item);
    out_t res;
    logic [LEN_W-1:0] sat_len;
    if (item.kind == KIND_HEADER) begin
      sat_len = (item.payload_length > 32'(LEN_SAT)) ? LEN_SAT
                                                      : item.payload_length[LEN_W-1:0];
      // A new header always abandons whatever packet is open
      pkt_bytes_left = '0;
      res.out_command = item.command;
      res.out_arg_zero = item.arg_zero;
      res.out_arg_one = item.arg_one;
      res.out_length = sat_len;
      if (item.magic_word != (item.command ^ ALL_ONES)) begin
        res.verdict = V_BAD_MAGIC;
        verdicts_due.push_back(res);
      end else if (item.payload_length > 32'(lim_payload)) begin
        res.verdict = V_TOO_LONG;
        verdicts_due.push_back(res);
      end else begin
        pkt_cmd = item.command;
        pkt_arg0 = item.arg_zero;
        pkt_arg1 = item.arg_one;
        pkt_check = item.check_word;
        pkt_len = item.payload_length[LEN_W-1:0];
        pkt_sum = '0;
        if (pkt_len == '0) finish_open_packet();
        else pkt_bytes_left = pkt_len;
      end
    end else if (pkt_bytes_left != '0) begin
      pkt_sum = pkt_sum + 32'(item.payload_byte);
      pkt_bytes_left = pkt_bytes_left - LEN_W'(1);
      if (pkt_bytes_left == '0) finish_open_packet();
    end
    // bytes with no packet open are dropped
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (verdicts_due.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual verdict %0d command %h length %0d",
               $time, got.verdict, got.out_command, got.out_length);
      fail_count++;
    end else begin
      want = verdicts_due.pop_front();
      results_seen++;
      verdicts_seen[want.verdict] = 1'b1;
      compare_field("verdict", 32'(want.verdict), 32'(got.verdict));
      compare_field("out_command", want.out_command, got.out_command);
      compare_field("out_arg_zero", want.out_arg_zero, got.out_arg_zero);
      compare_field("out_arg_one", want.out_arg_one, got.out_arg_one);
      compare_field("out_length", 32'(want.out_length), 32'(got.out_length));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pkt_bytes_left = '0;
      pkt_sum = '0;
      pkt_cmd = '0;
      pkt_arg0 = '0;
      pkt_arg1 = '0;
      pkt_check = '0;
      pkt_len = '0;
      link_online = 1'b0;
      lim_payload = LEN_LIMIT_RESET;
      token_want = '0;
      verdicts_due.delete();
    end else begin
      // Check the leaving result before queueing anything from this edge
      if (out_valid && out_ready) check_result(out_data);
      if (cfg_we) begin
        if (cfg_index == CFG_LEN_LIMIT) lim_payload = cfg_data[LEN_W-1:0];
        else token_want = cfg_data;
      end
      if (in_valid && in_ready) predict_verdict(in_data);
    end
    pending = verdicts_due.size();
  end

endmodule

### dv/tb_packet_header_checksum_sync_gate.sv
// Testbench top for the packet gate: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_packet_header_checksum_sync_gate;
  import phcs_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_LEN_LIMIT;
  logic [31:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  bit [7:0]    verdicts_seen;

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned phases_run = 0;

  // receiver stall pattern state
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall_run = 0;
  logic        rx_ready_next;

  logic [LEN_W-1:0]  max_now = LEN_LIMIT_RESET;
  logic [WORD_W-1:0] token_now = '0;

  packet_header_checksum_sync_gate dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  phcs_gate_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .verdicts_seen(verdicts_seen)
  );

  always #4 clk = ~clk;

  // Receiver: switch between stall patterns every so often, never stall forever
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(20, 120);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: rx_ready_next = 1'b1;
      1: rx_ready_next = 1'($urandom_range(0, 1));
      2: rx_ready_next = (rx_stall_run >= 5);
      default: rx_ready_next = ($urandom_range(0, 3) == 0) || (rx_stall_run >= 15);
    endcase
    out_ready <= rx_ready_next;
    rx_stall_run <= rx_ready_next ? 0 : rx_stall_run + 1;
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog: no transaction for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one transaction; bursts of random length with random gaps between them
  task automatic send_item(input in_t item);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Header followed by n_bytes payload bytes; the check word covers the first len bytes
  task automatic offer_packet(input logic [31:0] cmd, input logic [31:0] a0,
                              input logic [31:0] a1, input logic [31:0] len_field,
                              input int unsigned n_bytes, input bit sum_ok,
                              input bit magic_ok);
    in_t item;
    logic [7:0] body [$];
    logic [31:0] sum;
    sum = '0;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      body.push_back(pick_byte());
      if (i < len_field) sum = sum + 32'(body[i]);
    end
    item.kind = KIND_HEADER;
    item.command = cmd;
    item.arg_zero = a0;
    item.arg_one = a1;
    item.payload_length = len_field;
    item.check_word = sum_ok ? sum : (sum ^ ($urandom | 32'h1));
    item.magic_word = magic_ok ? (cmd ^ ALL_ONES) : ((cmd ^ ALL_ONES) ^ ($urandom | 32'h1));
    item.payload_byte = pick_byte();
    send_item(item);
    foreach (body[i]) begin
      item.kind = KIND_BYTE;
      item.command = $urandom;
      item.arg_zero = $urandom;
      item.arg_one = $urandom;
      item.payload_length = $urandom;
      item.check_word = $urandom;
      item.magic_word = $urandom;
      item.payload_byte = body[i];
      send_item(item);
    end
  endtask

  // Drop valid and wait until every expected result has left, then let the pipe settle
  task automatic await_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input cfg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] max_choices [8];
    logic [31:0] max_val;
    logic [31:0] tok;
    logic [31:0] cmd;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] big;
    int unsigned roll;
    int unsigned lim;
    int unsigned len;
    int unsigned target;
    in_t item;

    max_choices = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1048576, 32'd3, 32'd4096, 32'd7, 32'd16};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: max payload 4096, token zero, offline
    item = '0;
    item.kind = KIND_BYTE;
    item.command = ALL_ONES;
    item.payload_byte = 8'hFF;
    send_item(item);                                               // byte with nothing open
    offer_packet(ALL_ONES, '0, ALL_ONES, ALL_ONES, 0, 1'b1, 1'b0);  // bad magic, length saturates
    offer_packet(32'h1234_5678, 32'd1, 32'd2, 32'd4097, 0, 1'b1, 1'b1);
    offer_packet('0, '0, '0, ALL_ONES, 0, 1'b1, 1'b1);              // too long, saturated
    offer_packet(32'h0000_0001, $urandom, $urandom, '0, 0, 1'b1, 1'b1);
    offer_packet(32'h0000_0002, $urandom, $urandom, '0, 0, 1'b0, 1'b1);
    offer_packet(SYNC_COMMAND, '0, $urandom, '0, 0, 1'b1, 1'b1);    // go offline
    offer_packet(SYNC_COMMAND, 32'h1, '0, '0, 0, 1'b1, 1'b1);       // go online
    offer_packet('0, ALL_ONES, ALL_ONES, 32'd3, 3, 1'b1, 1'b1);
    offer_packet(32'hDEAD_BEEF, $urandom, $urandom, 32'd2, 2, 1'b0, 1'b1);
    offer_packet(SYNC_COMMAND, 32'd5, 32'd7, 32'd1, 1, 1'b1, 1'b1);  // sync ignored
    offer_packet(32'hA5A5_5A5A, $urandom, $urandom, 32'd5, 2, 1'b1, 1'b1);
    offer_packet('0, '0, '0, '0, 0, 1'b1, 1'b1);                    // abandons the open packet

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      await_idle();
      max_val = (ph < 8) ? max_choices[ph] : 32'($urandom_range(0, 40));
      case (ph % 3)
        0: tok = $urandom;
        1: tok = ALL_ONES;
        default: tok = '0;
      endcase
      program_reg(CFG_LEN_LIMIT, max_val);
      program_reg(CFG_EXPECTED_TOKEN, tok);
      max_now = max_val[LEN_W-1:0];
      token_now = tok;
      phases_run++;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 2) == 0) begin
          cmd = SYNC_COMMAND;
          a0 = ($urandom_range(0, 2) == 0) ? '0 : $urandom;
          a1 = ($urandom_range(0, 1) == 0) ? token_now : $urandom;
        end else begin
          cmd = $urandom;
          a0 = $urandom;
          a1 = $urandom;
        end
        lim = (max_now < 12) ? 32'(max_now) : 12;
        if ($urandom_range(0, 29) == 0) lim = (max_now < 300) ? 32'(max_now) : 300;
        len = $urandom_range(0, lim);
        if (roll < 70) begin
          offer_packet(cmd, a0, a1, 32'(len), len, roll < 64, 1'b1);
        end else if (roll < 80) begin
          offer_packet(cmd, a0, a1, $urandom, $urandom_range(0, 2), 1'b1, 1'b0);
        end else if (roll < 88) begin
          big = ($urandom_range(0, 1) == 0) ? ALL_ONES
                                             : 32'(max_now) + 32'($urandom_range(1, 64));
          offer_packet(cmd, a0, a1, big, $urandom_range(0, 2), 1'b1, 1'b1);
        end else if (roll < 94 && lim >= 2) begin
          // open a packet and leave it short; the next header abandons it
          len = $urandom_range(2, lim);
          offer_packet(cmd, a0, a1, 32'(len), $urandom_range(1, len - 1), 1'b1, 1'b1);
        end else begin
          // trailing bytes after a finished packet are discarded
          offer_packet(cmd, a0, a1, 32'(len), len + $urandom_range(1, 3), 1'b1, 1'b1);
        end
      end
    end

    await_idle();

    $display("Run covered %0d input transactions under %0d register settings,",
             items_sent, phases_run + 1);
    $display("%0d results checked; verdict codes seen, one bit per code from 7 down to 0: %b",
             results_seen, verdicts_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
